/* design/dgp1_pkg.sv */
// dgp1_pkg: shared types, fixed-point constants and helpers for the dg p1 euler cell residual
// depends on nothing; used by the core, dgp1_lane and the bench
`timescale 1ns / 1ps
`default_nettype none

package dgp1_pkg;

    // one cell beat in
    typedef struct packed {
        logic signed [31:0] rho_mean;
        logic signed [31:0] mom_mean;
        logic signed [31:0] energy_mean;
        logic signed [31:0] rho_slope;
        logic signed [31:0] mom_slope;
        logic signed [31:0] energy_slope;
        logic signed [31:0] left_flux_mass;
        logic signed [31:0] left_flux_mom;
        logic signed [31:0] left_flux_energy;
        logic signed [31:0] right_flux_mass;
        logic signed [31:0] right_flux_mom;
        logic signed [31:0] right_flux_energy;
    } t_cell_in;

    // one residual beat out
    typedef struct packed {
        logic signed [31:0] rhs_mass_mean;
        logic signed [31:0] rhs_mom_mean;
        logic signed [31:0] rhs_energy_mean;
        logic signed [31:0] rhs_mass_slope;
        logic signed [31:0] rhs_mom_slope;
        logic signed [31:0] rhs_energy_slope;
        logic               bad_density;
    } t_rhs_out;

    // quadrature constants with 30 fraction bits
    localparam int CBITS = 30;
    localparam logic signed [31:0] C_INV_SQRT3 = 32'sd619925131;
    localparam logic signed [31:0] C_SQRT_3_5  = 32'sd831716840;
    localparam logic signed [31:0] C_W8        = 32'sd954437177;
    localparam logic signed [31:0] C_W5        = 32'sd596523236;

    // gamma - 1 register
    localparam int          G1_W     = 18;
    localparam logic [17:0] G1_RESET = 18'd26214;

    localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;

    // divider quotient widths; larger magnitudes only matter as saturation
    localparam int Q_QUO_BITS = 34;
    localparam int G_QUO_BITS = 32;

    // lane: square, q divider, four flux stages, g divider, output stage
    localparam int LANE_LAT = Q_QUO_BITS + G_QUO_BITS + 8;

    // clamp a wide value to 32 bits signed
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] y;
        if (x > 64'(S32_MAX)) begin
            y = S32_MAX;
        end else if (x < 64'(S32_MIN)) begin
            y = S32_MIN;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

    // product with a 30-bit constant, rounded half up
    function automatic logic signed [63:0] rnd_c(input logic signed [63:0] x);
        return (x + (64'sd1 <<< (CBITS - 1))) >>> CBITS;
    endfunction

endpackage

`default_nettype wire

/* design/dg_p1_euler_cell_residual_core.sv */
// dg_p1_euler_cell_residual_core: top level of the dg p1 euler cell residual pipeline
// depends on dgp1_pkg, dgp1_lane, dgp1_divpipe and dgp1_delay
//
//  channel  ports                         direction  handshake
//  cell     start, busy, i_cell           in         beat taken when start && !busy
//  rhs      o_valid, o_rhs                out        one-cycle strobe, no back-pressure
//  config   i_cfg_we, i_cfg_wdata         in         written on every edge with i_cfg_we
//
// one cell beat enters every cycle; busy is held low
// a result passes the input register, the slope and point stages, the flux lanes and the back stages;
// the depth is set by the two bit-per-stage dividers in each quadrature lane
// synchronous active-low reset clears all valid bits and loads gamma - 1 = 0.4
// the receiver cannot stall, so nothing in the pipeline ever holds
`timescale 1ns / 1ps
`default_nettype none

module dg_p1_euler_cell_residual_core #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire dgp1_pkg::t_cell_in  i_cell,
    output logic                     o_valid,
    output dgp1_pkg::t_rhs_out       o_rhs,
    input  wire logic                i_cfg_we,
    input  wire logic [dgp1_pkg::G1_W-1:0] i_cfg_wdata
);
    import dgp1_pkg::*;

    localparam int SIDE_W = 4 * 32 + 33 + 33 + 1;

    assign busy = 1'b0;

    // gamma - 1 register
    logic [G1_W-1:0] r_g1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g1 <= G1_RESET;
        end else if (i_cfg_we) begin
            r_g1 <= i_cfg_wdata;
        end
    end

    // stage 1: input register
    logic     r1_vld;
    t_cell_in r1_cell;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= start && !busy;
        end
        r1_cell <= i_cell;
    end

    // stage 2: slope products and face terms
    logic signed [31:0] s1_u [3];
    logic signed [31:0] s1_x [3];

    assign s1_u[0] = r1_cell.rho_mean;
    assign s1_u[1] = r1_cell.mom_mean;
    assign s1_u[2] = r1_cell.energy_mean;
    assign s1_x[0] = r1_cell.rho_slope;
    assign s1_x[1] = r1_cell.mom_slope;
    assign s1_x[2] = r1_cell.energy_slope;

    logic               r2_vld;
    logic signed [31:0] r2_u  [3];
    logic signed [63:0] r2_p3 [3];
    logic signed [63:0] r2_p5 [3];
    logic signed [31:0] r2_res0, r2_res1, r2_res2, r2_res3;
    logic signed [32:0] r2_fs_mom, r2_fs_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        for (int j = 0; j < 3; j++) begin
            r2_u[j]  <= s1_u[j];
            r2_p3[j] <= 64'(s1_x[j]) * 64'(C_INV_SQRT3);
            r2_p5[j] <= 64'(s1_x[j]) * 64'(C_SQRT_3_5);
        end
        r2_res0 <= sat32(64'(r1_cell.left_flux_mass) - 64'(r1_cell.right_flux_mass));
        r2_res1 <= sat32(64'(r1_cell.left_flux_mom) - 64'(r1_cell.right_flux_mom));
        r2_res2 <= sat32(64'(r1_cell.left_flux_energy) - 64'(r1_cell.right_flux_energy));
        r2_res3 <= sat32(64'(r1_cell.mom_mean) + 64'(r1_cell.mom_mean)
                         - 64'(r1_cell.left_flux_mass) - 64'(r1_cell.right_flux_mass));
        r2_fs_mom <= 33'(r1_cell.left_flux_mom) + 33'(r1_cell.right_flux_mom);
        r2_fs_en  <= 33'(r1_cell.left_flux_energy) + 33'(r1_cell.right_flux_energy);
    end

    // stage 3: values at the five quadrature points and the density check
    logic signed [31:0] n3_pt [5][3];
    logic signed [63:0] d3 [3];
    logic signed [63:0] d5 [3];
    logic               n3_bad;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            d3[j] = rnd_c(r2_p3[j]);
            d5[j] = rnd_c(r2_p5[j]);
            n3_pt[0][j] = sat32(64'(r2_u[j]) + d3[j]);
            n3_pt[1][j] = sat32(64'(r2_u[j]) - d3[j]);
            n3_pt[2][j] = r2_u[j];
            n3_pt[3][j] = sat32(64'(r2_u[j]) + d5[j]);
            n3_pt[4][j] = sat32(64'(r2_u[j]) - d5[j]);
        end
        n3_bad = 1'b0;
        for (int k = 0; k < 5; k++) begin
            if (n3_pt[k][0] <= 32'sd0) begin
                n3_bad = 1'b1;
            end
        end
    end

    logic               r3_vld;
    logic signed [31:0] r3_pt [5][3];
    logic [SIDE_W-1:0]  r3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        r3_pt   <= n3_pt;
        r3_side <= {r2_res0, r2_res1, r2_res2, r2_res3, r2_fs_mom, r2_fs_en, n3_bad};
    end

    // flux lanes: points 0 and 1 give momentum flux, points 2 to 4 energy flux
    logic [4:0]         lane_vld;
    logic signed [31:0] lane_flux [5];

    for (genvar k = 0; k < 5; k++) begin : g_lane
        dgp1_lane #(
            .FRAC_BITS (FRAC_BITS),
            .MOM_FLUX  (k < 2)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r3_vld),
            .i_r     (r3_pt[k][0]),
            .i_m     (r3_pt[k][1]),
            .i_e     (r3_pt[k][2]),
            .i_g1    (r_g1),
            .o_valid (lane_vld[k]),
            .o_flux  (lane_flux[k])
        );
    end

    // face terms wait for the lanes
    logic [SIDE_W-1:0] dl_side;

    dgp1_delay #(.W(SIDE_W), .DEPTH(LANE_LAT)) u_side_dly (
        .i_clk  (i_clk),
        .i_data (r3_side),
        .o_data (dl_side)
    );

    logic signed [31:0] dl_res0, dl_res1, dl_res2, dl_res3;
    logic signed [32:0] dl_fs_mom, dl_fs_en;
    logic               dl_bad;

    assign {dl_res0, dl_res1, dl_res2, dl_res3, dl_fs_mom, dl_fs_en, dl_bad} = dl_side;

    // back stage 1: quadrature weights and momentum slope term
    logic               r4_vld;
    logic signed [63:0] r4_w8, r4_w5a, r4_w5b;
    logic signed [31:0] r4_res0, r4_res1, r4_res2, r4_res3, r4_mom;
    logic signed [32:0] r4_fs_en;
    logic               r4_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= &lane_vld;
        end
        r4_w8    <= 64'(lane_flux[2]) * 64'(C_W8);
        r4_w5a   <= 64'(lane_flux[3]) * 64'(C_W5);
        r4_w5b   <= 64'(lane_flux[4]) * 64'(C_W5);
        r4_mom   <= sat32(64'(lane_flux[0]) + 64'(lane_flux[1]) - 64'(dl_fs_mom));
        r4_res0  <= dl_res0;
        r4_res1  <= dl_res1;
        r4_res2  <= dl_res2;
        r4_res3  <= dl_res3;
        r4_fs_en <= dl_fs_en;
        r4_bad   <= dl_bad;
    end

    // back stage 2: energy slope term and result beat
    logic     r_out_vld;
    t_rhs_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r4_vld;
        end
        r_out.rhs_mass_mean    <= r4_res0;
        r_out.rhs_mom_mean     <= r4_res1;
        r_out.rhs_energy_mean  <= r4_res2;
        r_out.rhs_mass_slope   <= r4_res3;
        r_out.rhs_mom_slope    <= r4_mom;
        r_out.rhs_energy_slope <= sat32(rnd_c(r4_w8) + rnd_c(r4_w5a) + rnd_c(r4_w5b)
                                        - 64'(r4_fs_en));
        r_out.bad_density      <= r4_bad;
    end

    assign o_valid = r_out_vld;
    assign o_rhs   = r_out;

endmodule

`default_nettype wire

/* design/dgp1_divpipe.sv */
// dgp1_divpipe: unsigned restoring divider, one quotient bit per stage, with overflow flag
// carries a sideband word alongside; no package dependency
`timescale 1ns / 1ps
`default_nettype none

module dgp1_divpipe #(
    parameter int NW = 64,
    parameter int DW = 32,
    parameter int QW = 34,
    parameter int SW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [SW-1:0] i_side,
    output logic               o_valid,
    output logic [QW-1:0]      o_quo,
    output logic               o_ovf,
    output logic [SW-1:0]      o_side
);

    localparam int HW = NW - QW;
    localparam int CW = (HW > DW) ? HW : DW;

    logic          r_vld  [QW+1];
    logic [DW-1:0] r_rem  [QW+1];
    logic [QW-1:0] r_lq   [QW+1];
    logic [DW-1:0] r_den  [QW+1];
    logic          r_ovf  [QW+1];
    logic [SW-1:0] r_side [QW+1];

    logic [CW-1:0] hi_x, den_x;

    assign hi_x  = CW'(i_num[NW-1:QW]);
    assign den_x = CW'(i_den);

    // entry stage: overflow when the quotient would not fit in QW bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
        r_rem[0]  <= DW'(i_num[NW-1:QW]);
        r_lq[0]   <= i_num[QW-1:0];
        r_den[0]  <= i_den;
        r_ovf[0]  <= (hi_x >= den_x);
        r_side[0] <= i_side;
    end

    // one restoring step per stage; quotient bits shift in behind the numerator
    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [DW:0]   trial;
        logic          ge;
        logic [DW:0]   diff;

        assign trial = {r_rem[k-1], r_lq[k-1][QW-1]};
        assign ge    = (trial >= {1'b0, r_den[k-1]});
        assign diff  = trial - {1'b0, r_den[k-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= r_vld[k-1];
            end
            r_rem[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
            r_lq[k]   <= {r_lq[k-1][QW-2:0], ge};
            r_den[k]  <= r_den[k-1];
            r_ovf[k]  <= r_ovf[k-1];
            r_side[k] <= r_side[k-1];
        end
    end

    assign o_valid = r_vld[QW];
    assign o_quo   = r_lq[QW];
    assign o_ovf   = r_ovf[QW];
    assign o_side  = r_side[QW];

endmodule

`default_nettype wire

/* design/dgp1_lane.sv */
// dgp1_lane: flux of one quadrature point: q = m*m/r, pressure, F = q + p, G = m*(e+p)/r
// depends on dgp1_pkg and dgp1_divpipe
`timescale 1ns / 1ps
`default_nettype none

module dgp1_lane #(
    parameter int FRAC_BITS = 16,
    parameter bit MOM_FLUX  = 1'b1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic signed [31:0] i_r,
    input  wire logic signed [31:0] i_m,
    input  wire logic signed [31:0] i_e,
    input  wire logic [dgp1_pkg::G1_W-1:0] i_g1,
    output logic                    o_valid,
    output logic signed [31:0]      o_flux
);
    import dgp1_pkg::*;

    localparam int QB = Q_QUO_BITS;
    localparam int GB = G_QUO_BITS;

    // stage a: square of momentum
    logic               r_a_vld;
    logic [63:0]        r_a_num;
    logic [31:0]        r_a_den;
    logic signed [31:0] r_a_r, r_a_m, r_a_e;
    logic [31:0]        m_abs, r_abs;

    assign m_abs = i_m[31] ? 32'(-i_m) : 32'(i_m);
    assign r_abs = i_r[31] ? 32'(-i_r) : 32'(i_r);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= i_valid;
        end
        r_a_num <= 64'(m_abs) * 64'(m_abs);
        r_a_den <= r_abs;
        r_a_r   <= i_r;
        r_a_m   <= i_m;
        r_a_e   <= i_e;
    end

    // q divider
    logic          q_vld, q_ovf;
    logic [QB-1:0] q_quo;
    logic [95:0]   q_side;

    dgp1_divpipe #(.NW(64), .DW(32), .QW(QB), .SW(96)) u_qdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_a_vld),
        .i_num   (r_a_num),
        .i_den   (r_a_den),
        .i_side  ({r_a_r, r_a_m, r_a_e}),
        .o_valid (q_vld),
        .o_quo   (q_quo),
        .o_ovf   (q_ovf),
        .o_side  (q_side)
    );

    logic signed [31:0] q_r, q_m, q_e;
    assign q_r = q_side[95:64];
    assign q_m = q_side[63:32];
    assign q_e = q_side[31:0];

    // stage b: signed q, kinetic term and internal energy
    logic [QB:0]        q_mag;
    logic signed [63:0] q_pos, k_pos, q_w, k_w;
    logic               r_b_vld;
    logic signed [QB+1:0] r_b_q;
    logic signed [31:0] r_b_d, r_b_e, r_b_m, r_b_r;

    always_comb begin
        if (q_m == 32'sd0) begin
            q_mag = '0;
        end else if (q_ovf) begin
            q_mag = {1'b1, {QB{1'b0}}};
        end else begin
            q_mag = {1'b0, q_quo};
        end
        q_pos = 64'(q_mag);
        k_pos = 64'(q_mag >> 1);
        q_w   = q_r[31] ? -q_pos : q_pos;
        k_w   = q_r[31] ? -k_pos : k_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= q_vld;
        end
        r_b_q <= (QB+2)'(q_w);
        r_b_d <= sat32(64'(q_e) - k_w);
        r_b_e <= q_e;
        r_b_m <= q_m;
        r_b_r <= q_r;
    end

    // stage c: internal energy times gamma - 1
    logic               r_c_vld;
    logic signed [50:0] r_c_prod;
    logic signed [QB+1:0] r_c_q;
    logic signed [31:0] r_c_e, r_c_m, r_c_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= r_b_vld;
        end
        r_c_prod <= 51'(r_b_d) * 51'($signed({1'b0, i_g1}));
        r_c_q    <= r_b_q;
        r_c_e    <= r_b_e;
        r_c_m    <= r_b_m;
        r_c_r    <= r_b_r;
    end

    // stage d: pressure, momentum flux and e + p
    logic signed [63:0] p_rnd, p_w;
    logic               r_d_vld;
    logic signed [31:0] r_d_fm, r_d_s, r_d_m, r_d_r;

    assign p_rnd = (64'(r_c_prod) + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    assign p_w   = 64'(sat32(p_rnd));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= r_c_vld;
        end
        r_d_fm <= sat32(64'(r_c_q) + p_w);
        r_d_s  <= sat32(64'(r_c_e) + p_w);
        r_d_m  <= r_c_m;
        r_d_r  <= r_c_r;
    end

    // stage e: energy flux numerator as sign and magnitude
    logic signed [63:0] num2;
    logic [31:0]        rd_abs;
    logic               r_e_vld, r_e_neg, r_e_zero;
    logic [63:0]        r_e_mag;
    logic [31:0]        r_e_den;
    logic signed [31:0] r_e_fm;

    assign num2   = 64'(r_d_m) * 64'(r_d_s);
    assign rd_abs = r_d_r[31] ? 32'(-r_d_r) : 32'(r_d_r);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else begin
            r_e_vld <= r_d_vld;
        end
        r_e_mag  <= num2[63] ? 64'(-num2) : 64'(num2);
        r_e_neg  <= num2[63] ^ r_d_r[31];
        r_e_zero <= (num2 == 64'sd0);
        r_e_den  <= rd_abs;
        r_e_fm   <= r_d_fm;
    end

    // g divider
    logic          g_vld, g_ovf;
    logic [GB-1:0] g_quo;
    logic [33:0]   g_side;

    dgp1_divpipe #(.NW(64), .DW(32), .QW(GB), .SW(34)) u_gdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_e_vld),
        .i_num   (r_e_mag),
        .i_den   (r_e_den),
        .i_side  ({r_e_fm, r_e_neg, r_e_zero}),
        .o_valid (g_vld),
        .o_quo   (g_quo),
        .o_ovf   (g_ovf),
        .o_side  (g_side)
    );

    // stage f: signed, saturated energy flux and lane output
    logic signed [31:0] g_fm, fe;
    logic               g_neg, g_zero;
    logic signed [63:0] g_pos, g_val;
    logic               r_f_vld;
    logic signed [31:0] r_f_flux;

    assign g_fm   = g_side[33:2];
    assign g_neg  = g_side[1];
    assign g_zero = g_side[0];
    assign g_pos  = 64'(g_quo);
    assign g_val  = g_neg ? -g_pos : g_pos;

    always_comb begin
        if (g_zero) begin
            fe = 32'sd0;
        end else if (g_ovf) begin
            fe = g_neg ? S32_MIN : S32_MAX;
        end else begin
            fe = sat32(g_val);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= g_vld;
        end
        r_f_flux <= MOM_FLUX ? g_fm : fe;
    end

    assign o_valid = r_f_vld;
    assign o_flux  = r_f_flux;

endmodule

`default_nettype wire

/* design/dgp1_delay.sv */
// dgp1_delay: fixed-depth shift line that keeps face terms in step with the flux lanes
// no package dependency
`timescale 1ns / 1ps
`default_nettype none

module dgp1_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  wire logic         i_clk,
    input  wire logic [W-1:0] i_data,
    output logic [W-1:0]      o_data
);

    logic [W-1:0] r_tap [DEPTH];

    // shift by one tap every cycle
    always_ff @(posedge i_clk) begin
        r_tap[0] <= i_data;
        for (int k = 1; k < DEPTH; k++) begin
            r_tap[k] <= r_tap[k-1];
        end
    end

    assign o_data = r_tap[DEPTH-1];

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// tb_top: self-checking bench for dg_p1_euler_cell_residual_core
// depends on dgp1_pkg and the core; predicts each residual beat and compares in order
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
    import dgp1_pkg::*;

    localparam int FRAC = 16;
    localparam int PIPE_LAT = LANE_LAT + 5;

    localparam longint K_INV_SQRT3 = 64'sd619925131;
    localparam longint K_SQRT_3_5  = 64'sd831716840;
    localparam longint K_W8        = 64'sd954437177;
    localparam longint K_W5        = 64'sd596523236;
    localparam longint HUGE_Q      = 64'sd1 << 40;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    t_cell_in          i_cell = '0;
    logic              o_valid;
    t_rhs_out          o_rhs;
    logic              i_cfg_we = 1'b0;
    logic [G1_W-1:0]   i_cfg_wdata = '0;

    logic [G1_W-1:0]   g1_model = G1_RESET;
    t_rhs_out          rhs_expected[$];
    int                n_errors = 0;
    bit                no_idle = 1'b0;

    dg_p1_euler_cell_residual_core #(.FRAC_BITS(FRAC)) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cell     (i_cell),
        .o_valid    (o_valid),
        .o_rhs      (o_rhs),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    // clamp to 32-bit signed range
    function automatic longint clamp32(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // floor((p + half) >> sh)
    function automatic longint round_half_up(input longint p, input int sh);
        return (p + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint quad_value(input longint u, input longint ux,
                                          input longint c, input bit plus_side);
        longint d;
        d = round_half_up(ux * c, 30);
        return clamp32(plus_side ? u + d : u - d);
    endfunction

    // euler momentum and energy flux at one quadrature point
    function automatic void euler_flux(input longint r, input longint m, input longint e,
                                       input logic [G1_W-1:0] g1,
                                       output longint fm, output longint fe);
        longint q, d, p, s, num;
        if (r != 0) q = (m * m) / r;
        else q = (m == 0) ? 0 : HUGE_Q;
        d = clamp32(e - q / 2);
        p = clamp32(round_half_up(d * longint'(g1), FRAC));
        fm = clamp32(q + p);
        s = clamp32(e + p);
        num = m * s;
        if (r != 0) fe = clamp32(num / r);
        else fe = (num > 0) ? 64'sd2147483647 : ((num < 0) ? -64'sd2147483648 : 0);
    endfunction

    function automatic t_rhs_out predict_residual(input t_cell_in c,
                                                  input logic [G1_W-1:0] g1);
        t_rhs_out o;
        longint pr[5], pm[5], pe[5], fm[5], fe[5];
        longint lm, lp, le, rm, rp, re;
        bit bad;
        bad = 1'b0;
        lm = longint'(c.left_flux_mass);
        lp = longint'(c.left_flux_mom);
        le = longint'(c.left_flux_energy);
        rm = longint'(c.right_flux_mass);
        rp = longint'(c.right_flux_mom);
        re = longint'(c.right_flux_energy);
        for (int i = 0; i < 5; i++) begin
            longint k;
            bit pl;
            k = (i < 2) ? K_INV_SQRT3 : K_SQRT_3_5;
            pl = (i == 0 || i == 3);
            if (i == 2) begin
                pr[i] = longint'(c.rho_mean);
                pm[i] = longint'(c.mom_mean);
                pe[i] = longint'(c.energy_mean);
            end else begin
                pr[i] = quad_value(longint'(c.rho_mean), longint'(c.rho_slope), k, pl);
                pm[i] = quad_value(longint'(c.mom_mean), longint'(c.mom_slope), k, pl);
                pe[i] = quad_value(longint'(c.energy_mean), longint'(c.energy_slope), k, pl);
            end
            if (pr[i] <= 0) bad = 1'b1;
            euler_flux(pr[i], pm[i], pe[i], g1, fm[i], fe[i]);
        end
        o.rhs_mass_mean    = 32'(clamp32(lm - rm));
        o.rhs_mom_mean     = 32'(clamp32(lp - rp));
        o.rhs_energy_mean  = 32'(clamp32(le - re));
        o.rhs_mass_slope   = 32'(clamp32(2 * longint'(c.mom_mean) - (lm + rm)));
        o.rhs_mom_slope    = 32'(clamp32(fm[0] + fm[1] - (lp + rp)));
        o.rhs_energy_slope = 32'(clamp32(round_half_up(fe[2] * K_W8, 30)
                                         + round_half_up(fe[3] * K_W5, 30)
                                         + round_half_up(fe[4] * K_W5, 30) - (le + re)));
        o.bad_density      = bad;
        return o;
    endfunction

    // send one cell beat, with random idle cycles
    task automatic send_cell(input t_cell_in c);
        while (!no_idle && $urandom_range(99) < 27) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start  <= 1'b1;
        i_cell <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        rhs_expected.push_back(predict_residual(c, g1_model));
        @(negedge i_clk);
    endtask

    // wait for the pipe to drain fully
    task automatic drain_pipe();
        start <= 1'b0;
        while (rhs_expected.size() != 0) @(negedge i_clk);
        repeat (PIPE_LAT + 10) @(negedge i_clk);
    endtask

    task automatic write_gamma(input logic [G1_W-1:0] v);
        drain_pipe();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        g1_model     = v;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($urandom_range(20)) << 16;
            2: return -(32'($urandom_range(20)) << 16);
            3: return $urandom_range(65535);
            4: return {$urandom} >> $urandom_range(31);
            default: return (32'($urandom_range(8)) << 16) + $urandom_range(65535);
        endcase
    endfunction

    // random cell; when physical: positive density, modest slopes; else random mean and slope words
    function automatic t_cell_in rand_cell(input bit physical);
        t_cell_in c;
        c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        if (!physical) begin
            c.rho_mean = rand_word(); c.mom_mean = rand_word();
            c.energy_mean = rand_word(); c.rho_slope = rand_word();
            c.mom_slope = rand_word(); c.energy_slope = rand_word();
            return c;
        end
        c.rho_mean     = 32'($urandom_range(32'h0010_0000, 32'h0000_1000));
        c.rho_slope    = $signed(32'($urandom_range(32'h0008_0000))) - 32'sh0004_0000;
        c.mom_mean     = $signed(32'($urandom_range(32'h0040_0000))) - 32'sh0020_0000;
        c.mom_slope    = $signed(32'($urandom_range(32'h0010_0000))) - 32'sh0008_0000;
        c.energy_mean  = 32'($urandom_range(32'h0080_0000, 32'h0001_0000));
        c.energy_slope = $signed(32'($urandom_range(32'h0010_0000))) - 32'sh0008_0000;
        c.left_flux_mass   = $signed(32'($urandom_range(32'h0100_0000))) - 32'sh0080_0000;
        c.left_flux_mom    = $signed(32'($urandom_range(32'h0100_0000))) - 32'sh0080_0000;
        c.left_flux_energy = $signed(32'($urandom_range(32'h0100_0000))) - 32'sh0080_0000;
        return c;
    endfunction

    // directed: field extremes, zero and negative density, saturation
    task automatic test_directed();
        t_cell_in c;
        logic [31:0] vals[6];
        vals = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h0001_0000, 32'h1};
        foreach (vals[i]) begin
            c = {12{vals[i]}};
            send_cell(c);
        end
        c = '0; c.mom_mean = 32'h0002_0000; c.energy_mean = 32'h0003_0000;
        send_cell(c);                           // zero density, nonzero momentum
        c = '0; c.energy_mean = 32'h0001_0000;
        send_cell(c);                           // zero density and momentum
        c = rand_cell(1); c.rho_mean = -32'sh0001_0000;
        send_cell(c);                           // negative density
        c = rand_cell(1); c.rho_slope = 32'sh7fff_0000;
        send_cell(c);                           // outer points dip below zero
        c = rand_cell(1); c.left_flux_mass = S32_MAX; c.right_flux_mass = S32_MIN;
        c.left_flux_mom = S32_MIN; c.right_flux_mom = S32_MAX;
        c.left_flux_energy = S32_MAX; c.right_flux_energy = S32_MIN;
        send_cell(c);                           // flux difference saturation
        c.left_flux_mass = S32_MAX; c.right_flux_mass = S32_MAX; c.mom_mean = S32_MIN;
        send_cell(c);
        c = rand_cell(1); c.rho_mean = 32'h0000_0001; c.rho_slope = 32'sd0;
        c.mom_mean = S32_MAX;
        send_cell(c);                           // tiny density, huge q
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++) begin
            no_idle = (i >= n / 3 && i < n / 3 + 150);
            send_cell(rand_cell($urandom_range(99) < 75));
        end
        no_idle = 1'b0;
    endtask

    task automatic test_gamma_settings();
        logic [G1_W-1:0] g[4];
        g = '{18'd0, 18'd131072, 18'd26214, 18'd65536};
        foreach (g[i]) begin
            write_gamma(g[i]);
            test_random(60);
        end
        write_gamma(18'h3ffff);
        test_random(40);
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (rhs_expected.size() == 0) begin
                $display("%0t: unexpected residual beat %h", $time, o_rhs);
                n_errors++;
            end else begin
                t_rhs_out x;
                x = rhs_expected.pop_front();
                if (o_rhs.rhs_mass_mean !== x.rhs_mass_mean)
                    $display("%0t: rhs_mass_mean exp %h got %h", $time,
                             x.rhs_mass_mean, o_rhs.rhs_mass_mean);
                if (o_rhs.rhs_mom_mean !== x.rhs_mom_mean)
                    $display("%0t: rhs_mom_mean exp %h got %h", $time,
                             x.rhs_mom_mean, o_rhs.rhs_mom_mean);
                if (o_rhs.rhs_energy_mean !== x.rhs_energy_mean)
                    $display("%0t: rhs_energy_mean exp %h got %h", $time,
                             x.rhs_energy_mean, o_rhs.rhs_energy_mean);
                if (o_rhs.rhs_mass_slope !== x.rhs_mass_slope)
                    $display("%0t: rhs_mass_slope exp %h got %h", $time,
                             x.rhs_mass_slope, o_rhs.rhs_mass_slope);
                if (o_rhs.rhs_mom_slope !== x.rhs_mom_slope)
                    $display("%0t: rhs_mom_slope exp %h got %h", $time,
                             x.rhs_mom_slope, o_rhs.rhs_mom_slope);
                if (o_rhs.rhs_energy_slope !== x.rhs_energy_slope)
                    $display("%0t: rhs_energy_slope exp %h got %h", $time,
                             x.rhs_energy_slope, o_rhs.rhs_energy_slope);
                if (o_rhs.bad_density !== x.bad_density)
                    $display("%0t: bad_density exp %b got %b", $time,
                             x.bad_density, o_rhs.bad_density);
                if (o_rhs !== x) n_errors++;
            end
        end
    end

    // run limit
    initial begin
        #20ms;
        $display("dg_p1_euler_cell_residual_core verification failed");
        $finish;
    end

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(750);
        drain_pipe();                           // sender holds off until all back
        test_random(750);
        test_gamma_settings();
        drain_pipe();
        if (n_errors == 0 && rhs_expected.size() == 0)
            $display("dg_p1_euler_cell_residual_core verification clean");
        else
            $display("dg_p1_euler_cell_residual_core verification failed");
        $finish;
    end
endmodule

`default_nettype wire

/* sim.f */
design/dgp1_pkg.sv
design/dgp1_divpipe.sv
design/dgp1_lane.sv
design/dgp1_delay.sv
design/dg_p1_euler_cell_residual_core.sv
tb/sv/tb_top.sv
